// ----- rtl/core/chip8_instruction_core_macros.svh -----
// ----------------------------------------------------------------------------
// chip8 instruction core assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH

// property holds at every clock edge outside reset
`define C8IC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("c8ic assertion failed");

// a condition in one cycle implies a condition in the next
`define C8IC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("c8ic assertion failed");

`endif

// ----- rtl/core/c8ic_pkg.sv -----
// ----------------------------------------------------------------------------
// c8ic_pkg
// Types, opcode constants and helper functions of the chip8 instruction core.
// ----------------------------------------------------------------------------
package c8ic_pkg;

  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned SCREEN_W  = 64;
  localparam int unsigned SCREEN_H  = 32;
  localparam int unsigned FONT_LEN  = 80;

  localparam logic [11:0] START_PC  = 12'h200;
  localparam logic [11:0] FONT_BASE = 12'h050;

  // host commands
  typedef enum logic [1:0] {
    CMD_POKE  = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_PIXEL = 2'd2,
    CMD_PEEK  = 2'd3
  } c8ic_cmd_e;

  // whole opcodes
  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  // opcode top nibble
  localparam logic [3:0] HD_SYS    = 4'h0;
  localparam logic [3:0] HD_JP     = 4'h1;
  localparam logic [3:0] HD_CALL   = 4'h2;
  localparam logic [3:0] HD_SE_NN  = 4'h3;
  localparam logic [3:0] HD_SNE_NN = 4'h4;
  localparam logic [3:0] HD_SE_V   = 4'h5;
  localparam logic [3:0] HD_LD_NN  = 4'h6;
  localparam logic [3:0] HD_ADD_NN = 4'h7;
  localparam logic [3:0] HD_ALU    = 4'h8;
  localparam logic [3:0] HD_SNE_V  = 4'h9;
  localparam logic [3:0] HD_LD_I   = 4'hA;
  localparam logic [3:0] HD_JP_V0  = 4'hB;
  localparam logic [3:0] HD_RND    = 4'hC;
  localparam logic [3:0] HD_DRW    = 4'hD;
  localparam logic [3:0] HD_KEY    = 4'hE;
  localparam logic [3:0] HD_MISC   = 4'hF;

  // register to register sub-codes
  localparam logic [3:0] AL_MOV  = 4'h0;
  localparam logic [3:0] AL_OR   = 4'h1;
  localparam logic [3:0] AL_AND  = 4'h2;
  localparam logic [3:0] AL_XOR  = 4'h3;
  localparam logic [3:0] AL_ADD  = 4'h4;
  localparam logic [3:0] AL_SUB  = 4'h5;
  localparam logic [3:0] AL_SHR  = 4'h6;
  localparam logic [3:0] AL_SUBN = 4'h7;
  localparam logic [3:0] AL_SHL  = 4'hE;

  // key and misc sub-codes
  localparam logic [7:0] KEY_NP     = 8'hA1;
  localparam logic [7:0] FX_GET_DT  = 8'h07;
  localparam logic [7:0] FX_KEY     = 8'h0A;
  localparam logic [7:0] FX_SET_DT  = 8'h15;
  localparam logic [7:0] FX_SET_ST  = 8'h18;
  localparam logic [7:0] FX_ADD_I   = 8'h1E;
  localparam logic [7:0] FX_FONT    = 8'h29;
  localparam logic [7:0] FX_BCD     = 8'h33;
  localparam logic [7:0] FX_SAVE    = 8'h55;
  localparam logic [7:0] FX_RESTORE = 8'h65;

  // datapath actions issued by the sequencer
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_INIT_WR,
    ACT_POKE,
    ACT_PIX_CAP,
    ACT_MEM_RD,
    ACT_MEM_CAP,
    ACT_FETCH_HI,
    ACT_FETCH_LO,
    ACT_OP_LO,
    ACT_READ_VY,
    ACT_READ_V0,
    ACT_EXEC,
    ACT_WRITE_VX,
    ACT_DRAW_RD,
    ACT_DRAW_XOR,
    ACT_DRAW_FLAG,
    ACT_BCD_WR,
    ACT_STORE_WR,
    ACT_FILL_RD,
    ACT_FILL_WR,
    ACT_OUT
  } c8ic_act_e;

  typedef struct packed {
    c8ic_act_e   act;
    logic [11:0] cnt;
  } c8ic_cmd_t;

  typedef struct packed {
    logic [15:0] op;
  } c8ic_sts_t;

  localparam logic [7:0] FONT_ROWS [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // power-up content of one memory byte
  function automatic logic [7:0] font_byte(input logic [11:0] a);
    logic [11:0] off;
    off = a - FONT_BASE;
    if (a >= FONT_BASE && a < FONT_BASE + 12'(FONT_LEN)) begin
      return FONT_ROWS[off[6:0]];
    end
    return 8'd0;
  endfunction

  // one decimal digit of a byte: 0 hundreds, 1 tens, else ones
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  hund;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem  = v - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
    // rem below 100, so rem*205/2048 is rem/10
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = rem - (8'({tens, 3'b000}) + 8'({tens, 1'b0}));
    case (sel)
      2'd0:    return {6'd0, hund};
      2'd1:    return {4'd0, tens};
      default: return ones;
    endcase
  endfunction

endpackage

// ----- rtl/core/c8ic_ctrl.sv -----
// ----------------------------------------------------------------------------
// c8ic_ctrl
// Sequencer: walks execute commands through fetch, decode, execute and the
// multi-cycle loops, runs other commands, owns input and output handshakes.
// ----------------------------------------------------------------------------
module c8ic_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  c8ic_pkg::c8ic_sts_t sts_i,
  output c8ic_pkg::c8ic_cmd_t cmd_o
);
  import c8ic_pkg::*;

  typedef enum logic [20:0] {
    ST_INIT  = 21'h000001,
    ST_IDLE  = 21'h000002,
    ST_LOADW = 21'h000004,
    ST_PIX   = 21'h000008,
    ST_MRD   = 21'h000010,
    ST_MCAP  = 21'h000020,
    ST_FHI   = 21'h000040,
    ST_FLO   = 21'h000080,
    ST_OPLO  = 21'h000100,
    ST_RVY   = 21'h000200,
    ST_RV0   = 21'h000400,
    ST_EXEC  = 21'h000800,
    ST_WX    = 21'h001000,
    ST_DRD   = 21'h002000,
    ST_DXOR  = 21'h004000,
    ST_DFLAG = 21'h008000,
    ST_BCD   = 21'h010000,
    ST_STORE = 21'h020000,
    ST_LRD   = 21'h040000,
    ST_LWR   = 21'h080000,
    ST_DONE  = 21'h100000
  } c8ic_state_e;

  c8ic_state_e state_q, state_d;
  logic [11:0] cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  c8ic_act_e   act;

  logic [3:0] head, x, n;
  logic [7:0] nn;

  assign head = sts_i.op[15:12];
  assign x    = sts_i.op[11:8];
  assign n    = sts_i.op[3:0];
  assign nn   = sts_i.op[7:0];

  // next state and action
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    act        = ACT_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        act   = ACT_INIT_WR;
        cnt_d = cnt_q + 12'd1;
        if (cnt_q == 12'hFFF) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          act = ACT_ACCEPT;
          case (command_i)
            CMD_POKE:  state_d = ST_LOADW;
            CMD_PIXEL: state_d = ST_PIX;
            CMD_PEEK:  state_d = ST_MRD;
            default:   state_d = ST_FHI;
          endcase
        end
      end
      ST_LOADW: begin
        act     = ACT_POKE;
        state_d = ST_DONE;
      end
      ST_PIX: begin
        act     = ACT_PIX_CAP;
        state_d = ST_DONE;
      end
      ST_MRD: begin
        act     = ACT_MEM_RD;
        state_d = ST_MCAP;
      end
      ST_MCAP: begin
        act     = ACT_MEM_CAP;
        state_d = ST_DONE;
      end
      ST_FHI: begin
        act     = ACT_FETCH_HI;
        state_d = ST_FLO;
      end
      ST_FLO: begin
        act     = ACT_FETCH_LO;
        state_d = ST_OPLO;
      end
      ST_OPLO: begin
        act     = ACT_OP_LO;
        state_d = ST_RVY;
      end
      ST_RVY: begin
        act     = ACT_READ_VY;
        state_d = ST_RV0;
      end
      ST_RV0: begin
        act     = ACT_READ_V0;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        act     = ACT_EXEC;
        cnt_d   = '0;
        state_d = ST_DONE;
        if (head == HD_ALU && (n == AL_ADD || n == AL_SUB || n == AL_SHR ||
                               n == AL_SUBN || n == AL_SHL)) begin
          state_d = ST_WX;
        end else if (head == HD_DRW) begin
          state_d = (n == 4'd0) ? ST_DFLAG : ST_DRD;
        end else if (head == HD_MISC) begin
          if (nn == FX_BCD) begin
            state_d = ST_BCD;
          end else if (nn == FX_SAVE) begin
            state_d = ST_STORE;
          end else if (nn == FX_RESTORE) begin
            state_d = ST_LRD;
          end
        end
      end
      ST_WX: begin
        act     = ACT_WRITE_VX;
        state_d = ST_DONE;
      end
      // sprite rows: fetch then merge
      ST_DRD: begin
        act     = ACT_DRAW_RD;
        state_d = ST_DXOR;
      end
      ST_DXOR: begin
        act = ACT_DRAW_XOR;
        if (cnt_q[3:0] == n - 4'd1) begin
          state_d = ST_DFLAG;
        end else begin
          cnt_d   = cnt_q + 12'd1;
          state_d = ST_DRD;
        end
      end
      ST_DFLAG: begin
        act     = ACT_DRAW_FLAG;
        state_d = ST_DONE;
      end
      ST_BCD: begin
        act = ACT_BCD_WR;
        if (cnt_q[1:0] == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 12'd1;
        end
      end
      ST_STORE: begin
        act = ACT_STORE_WR;
        if (cnt_q[3:0] == x) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 12'd1;
        end
      end
      ST_LRD: begin
        act     = ACT_FILL_RD;
        state_d = ST_LWR;
      end
      ST_LWR: begin
        act = ACT_FILL_WR;
        if (cnt_q[3:0] == x) begin
          state_d = ST_DONE;
        end else begin
          cnt_d   = cnt_q + 12'd1;
          state_d = ST_LRD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          act     = ACT_OUT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result beat holding register
  always_comb begin
    out_valid_d = out_valid_q;
    if (act == ACT_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.act   = act;
  assign cmd_o.cnt   = cnt_q;

endmodule

// ----- rtl/core/c8ic_dp.sv -----
// ----------------------------------------------------------------------------
// c8ic_dp
// Datapath: main memory, frame buffer, data registers, index, program
// counter, return stack, timers and the result register.
// ----------------------------------------------------------------------------
module c8ic_dp #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  c8ic_pkg::c8ic_cmd_t cmd_i,
  output c8ic_pkg::c8ic_sts_t sts_o,
  input  logic [11:0]         address_i,
  input  logic [7:0]          write_byte_i,
  input  logic [7:0]          random_byte_i,
  output logic [7:0]          read_data_o,
  output logic [11:0]         program_counter_o,
  output logic                sound_on_o
);
  import c8ic_pkg::*;

  localparam int unsigned SP_W = $clog2(STACK_DEPTH);

  c8ic_act_e act;
  logic [3:0] cnt4;

  // latched beat payload
  logic [11:0] addr_q;
  logic [7:0]  wb_q, rnd_q;

  // architectural state
  logic [11:0]     pc_q, pc_d, i_q, i_d;
  logic [SP_W-1:0] sp_q, sp_d, sp_inc, sp_dec;
  logic [7:0]      dt_q, dt_d, st_q, st_d;
  logic [7:0]      vregs_q [16];

  // working registers
  logic [15:0] op_q;
  logic [7:0]  vx_q, vy_q, v0_q, res_q, res_d, rdata_q, mem_rdata_q;
  logic        hit_q;

  // result register
  logic [7:0]  out_rd_q;
  logic [11:0] out_pc_q;
  logic        out_snd_q;

  logic [3:0]  head, x, n;
  logic [7:0]  nn;
  logic [11:0] nnn, ic_addr;

  assign act     = cmd_i.act;
  assign cnt4    = cmd_i.cnt[3:0];
  assign head    = op_q[15:12];
  assign x       = op_q[11:8];
  assign n       = op_q[3:0];
  assign nn      = op_q[7:0];
  assign nnn     = op_q[11:0];
  assign ic_addr = i_q + {8'd0, cnt4};
  assign sts_o.op = op_q;

  // data register read port
  logic [3:0] vrd_addr;
  logic [7:0] vreg_rd;

  always_comb begin
    case (act)
      ACT_READ_VY:  vrd_addr = op_q[7:4];
      ACT_READ_V0:  vrd_addr = 4'd0;
      ACT_STORE_WR: vrd_addr = cnt4;
      default:      vrd_addr = op_q[11:8];
    endcase
  end
  assign vreg_rd = vregs_q[vrd_addr];

  // main memory port
  logic [7:0]  mem_ram [MEM_BYTES];
  logic        mem_we, mem_re;
  logic [11:0] mem_addr;
  logic [7:0]  mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = ic_addr;
    mem_wdata = vreg_rd;
    case (act)
      ACT_INIT_WR: begin
        mem_we    = 1'b1;
        mem_addr  = cmd_i.cnt;
        mem_wdata = font_byte(cmd_i.cnt);
      end
      ACT_POKE: begin
        mem_we    = 1'b1;
        mem_addr  = addr_q;
        mem_wdata = wb_q;
      end
      ACT_MEM_RD: begin
        mem_re   = 1'b1;
        mem_addr = addr_q;
      end
      ACT_FETCH_HI: begin
        mem_re   = 1'b1;
        mem_addr = pc_q;
      end
      ACT_FETCH_LO: begin
        mem_re   = 1'b1;
        mem_addr = pc_q + 12'd1;
      end
      ACT_DRAW_RD, ACT_FILL_RD: mem_re = 1'b1;
      ACT_BCD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit(vx_q, cnt4[1:0]);
      end
      ACT_STORE_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_ram[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_ram[mem_addr];
    end
  end

  // frame buffer rows and sprite merge
  logic [SCREEN_W-1:0] frame_q [SCREEN_H];
  logic [4:0]          row_sel;
  logic [SCREEN_W-1:0] frow, spr_line, spr;
  logic [2*SCREEN_W-1:0] spr_rot;
  logic                frame_clr;

  assign row_sel = (act == ACT_PIX_CAP) ? addr_q[10:6] : (vy_q[4:0] + cmd_i.cnt[4:0]);
  assign frow    = frame_q[row_sel];

  always_comb begin
    spr_line = '0;
    for (int c = 0; c < 8; c++) begin
      spr_line[c] = mem_rdata_q[7-c];
    end
  end
  assign spr_rot = {spr_line, spr_line} << vx_q[5:0];
  assign spr     = spr_rot[2*SCREEN_W-1:SCREEN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '{default: '0};
    end else if (frame_clr) begin
      frame_q <= '{default: '0};
    end else if (act == ACT_DRAW_XOR) begin
      frame_q[row_sel] <= frow ^ spr;
    end
  end

  // return stack with per-entry valid bits
  logic [11:0]            stk_ram [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] stk_vld_q;
  logic [11:0]            stk_rd_q, stk_val;
  logic                   stk_hit_q, stk_we;

  assign sp_dec  = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - 1'b1;
  assign sp_inc  = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
  assign stk_val = stk_hit_q ? stk_rd_q : 12'd0;

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_ram[sp_q] <= pc_q;
    end
    if (act == ACT_READ_VY) begin
      stk_rd_q  <= stk_ram[sp_dec];
      stk_hit_q <= stk_vld_q[sp_dec];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stk_vld_q <= '0;
    end else if (stk_we) begin
      stk_vld_q[sp_q] <= 1'b1;
    end
  end

  // register to register alu
  logic       alu_flag;
  logic [7:0] alu_res;
  logic [8:0] sum9;

  assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};

  always_comb begin
    alu_flag = 1'b0;
    alu_res  = vy_q;
    case (n)
      AL_OR:   alu_res = vx_q | vy_q;
      AL_AND:  alu_res = vx_q & vy_q;
      AL_XOR:  alu_res = vx_q ^ vy_q;
      AL_ADD: begin
        alu_flag = sum9[8];
        alu_res  = sum9[7:0];
      end
      AL_SUB: begin
        alu_flag = (vx_q >= vy_q);
        alu_res  = vx_q - vy_q;
      end
      AL_SHR: begin
        alu_flag = vx_q[0];
        alu_res  = {1'b0, vx_q[7:1]};
      end
      AL_SUBN: begin
        alu_flag = (vy_q >= vx_q);
        alu_res  = vy_q - vx_q;
      end
      AL_SHL: begin
        alu_flag = vx_q[7];
        alu_res  = {vx_q[6:0], 1'b0};
      end
      default: alu_res = vy_q;
    endcase
  end

  // instruction execute
  logic       vwr_en;
  logic [3:0] vwr_addr;
  logic [7:0] vwr_data;

  always_comb begin
    pc_d      = pc_q;
    i_d       = i_q;
    sp_d      = sp_q;
    dt_d      = dt_q;
    st_d      = st_q;
    res_d     = res_q;
    vwr_en    = 1'b0;
    vwr_addr  = x;
    vwr_data  = alu_res;
    frame_clr = 1'b0;
    stk_we    = 1'b0;
    case (act)
      ACT_EXEC: begin
        pc_d = pc_q + 12'd2;
        case (head)
          HD_SYS: begin
            if (op_q == OP_CLS) begin
              frame_clr = 1'b1;
            end else if (op_q == OP_RET) begin
              sp_d = sp_dec;
              pc_d = stk_val + 12'd2;
            end
          end
          HD_JP: pc_d = nnn;
          HD_CALL: begin
            stk_we = 1'b1;
            sp_d   = sp_inc;
            pc_d   = nnn;
          end
          HD_SE_NN:  if (vx_q == nn) pc_d = pc_q + 12'd4;
          HD_SNE_NN: if (vx_q != nn) pc_d = pc_q + 12'd4;
          HD_SE_V:   if (vx_q == vy_q) pc_d = pc_q + 12'd4;
          HD_SNE_V:  if (vx_q != vy_q) pc_d = pc_q + 12'd4;
          HD_LD_NN: begin
            vwr_en   = 1'b1;
            vwr_data = nn;
          end
          HD_ADD_NN: begin
            vwr_en   = 1'b1;
            vwr_data = vx_q + nn;
          end
          HD_ALU: begin
            case (n)
              AL_MOV, AL_OR, AL_AND, AL_XOR: vwr_en = 1'b1;
              AL_ADD, AL_SUB, AL_SHR, AL_SUBN, AL_SHL: begin
                // flag first, result follows next cycle
                vwr_en   = 1'b1;
                vwr_addr = 4'hF;
                vwr_data = {7'd0, alu_flag};
                res_d    = alu_res;
              end
              default: ;
            endcase
          end
          HD_LD_I:  i_d = nnn;
          HD_JP_V0: pc_d = nnn + {4'd0, v0_q};
          HD_RND: begin
            vwr_en   = 1'b1;
            vwr_data = rnd_q & nn;
          end
          HD_KEY: if (nn == KEY_NP) pc_d = pc_q + 12'd4;
          HD_MISC: begin
            case (nn)
              FX_GET_DT: begin
                vwr_en   = 1'b1;
                vwr_data = dt_q;
              end
              FX_KEY: begin
                vwr_en   = 1'b1;
                vwr_data = 8'd0;
              end
              FX_SET_DT: dt_d = vx_q;
              FX_SET_ST: st_d = vx_q;
              FX_ADD_I:  i_d = i_q + {4'd0, vx_q};
              FX_FONT:   i_d = FONT_BASE + {2'd0, vx_q, 2'd0} + {4'd0, vx_q};
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ACT_WRITE_VX: begin
        vwr_en   = 1'b1;
        vwr_data = res_q;
      end
      ACT_DRAW_FLAG: begin
        vwr_en   = 1'b1;
        vwr_addr = 4'hF;
        vwr_data = {7'd0, hit_q};
      end
      ACT_FILL_WR: begin
        vwr_en   = 1'b1;
        vwr_addr = cnt4;
        vwr_data = mem_rdata_q;
      end
      default: ;
    endcase
  end

  // architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vregs_q <= '{default: '0};
      pc_q    <= START_PC;
      i_q     <= '0;
      sp_q    <= '0;
      dt_q    <= '0;
      st_q    <= '0;
    end else begin
      if (vwr_en) begin
        vregs_q[vwr_addr] <= vwr_data;
      end
      pc_q <= pc_d;
      i_q  <= i_d;
      sp_q <= sp_d;
      dt_q <= dt_d;
      st_q <= st_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    case (act)
      ACT_ACCEPT: begin
        addr_q  <= address_i;
        wb_q    <= write_byte_i;
        rnd_q   <= random_byte_i;
        rdata_q <= '0;
      end
      ACT_PIX_CAP:  rdata_q <= {7'd0, frow[addr_q[5:0]]};
      ACT_MEM_CAP:  rdata_q <= mem_rdata_q;
      ACT_FETCH_LO: op_q[15:8] <= mem_rdata_q;
      ACT_OP_LO: begin
        op_q[7:0] <= mem_rdata_q;
        vx_q      <= vreg_rd;
      end
      ACT_READ_VY: vy_q <= vreg_rd;
      ACT_READ_V0: v0_q <= vreg_rd;
      ACT_EXEC:    hit_q <= 1'b0;
      ACT_DRAW_XOR: hit_q <= hit_q | (|(frow & spr));
      ACT_OUT: begin
        out_rd_q  <= rdata_q;
        out_pc_q  <= pc_q;
        out_snd_q <= |st_q;
      end
      default: ;
    endcase
  end

  assign read_data_o       = out_rd_q;
  assign program_counter_o = out_pc_q;
  assign sound_on_o        = out_snd_q;

endmodule

// ----- rtl/core/chip8_instruction_core.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 core taking poke, execute, pixel read and peek commands, one result
// beat per command.
// ----------------------------------------------------------------------------
// After reset the core loads the memory (zeros with the hex font at 0x50)
// and takes no command meanwhile. All work goes through a single-port 4 KiB
// memory, one access a cycle, and each command ends in a state that waits
// for as long as the previous result beat stays untaken.
`include "chip8_instruction_core_macros.svh"

module chip8_instruction_core #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_byte_i,
  input  logic [7:0]  random_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [11:0] program_counter_o,
  output logic        sound_on_o
);
  import c8ic_pkg::*;

  c8ic_cmd_t cmd;
  c8ic_sts_t sts;

  // sequencer
  c8ic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  c8ic_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .address_i         (address_i),
    .write_byte_i      (write_byte_i),
    .random_byte_i     (random_byte_i),
    .read_data_o       (read_data_o),
    .program_counter_o (program_counter_o),
    .sound_on_o        (sound_on_o)
  );

  // no command taken while the memory is being loaded
  `C8IC_ASSERT(a_no_accept_in_init, !(cmd.act == ACT_INIT_WR && in_ready_o))
  // a command beat makes the core busy on the next cycle
  `C8IC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // a result beat appears only when the sequencer loads one
  `C8IC_ASSERT_NEXT(a_no_spurious_result, !out_valid_o && cmd.act != ACT_OUT, !out_valid_o)

endmodule
